// File: src/bcdm_pkg.sv
// Shared types, constants and helper functions for the battery cell
// detect and monitor unit. No dependencies; every other file depends on it.
package bcdm_pkg;

  // Field widths
  localparam int CODE_W   = 12;
  localparam int SCALE_W  = 12;
  localparam int MV_W     = 16;
  localparam int THR_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CELLS_W  = 3;
  localparam int CHARGE_W = 10;
  localparam int SUM_W    = 32;
  localparam int CNT_W    = 16;
  localparam int LWC_W    = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  // Shared divider
  localparam int DIV_W = 32;
  localparam int DSR_W = 16;

  // Default sample queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic REG_SCALE  = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET  = 12'd2240;
  localparam logic [THR_W-1:0]   WINDOW_RESET = 16'd40;

  // Detection window and voltage classes
  localparam int unsigned DETECT_SAMPLES = 20;
  localparam int unsigned DETECT_N       = DETECT_SAMPLES + 1;
  localparam int unsigned C3_LO_MV = 10100;
  localparam int unsigned C3_HI_MV = 13600;
  localparam int unsigned C4_LO_MV = 13800;
  localparam int unsigned C4_HI_MV = 17400;

  // Charge model, per cell
  localparam int unsigned CELL_EMPTY_MV = 3120;
  localparam int unsigned CELL_FULL_MV  = 4250;
  localparam int unsigned CELL_SPAN_MV  = CELL_FULL_MV - CELL_EMPTY_MV;
  localparam int unsigned PERMILLE      = 1000;
  localparam logic [CHARGE_W-1:0] CHARGE_CAP    = 10'd990;
  localparam logic [CHARGE_W-1:0] LOW3_PERMILLE = 10'd30;
  localparam logic [CHARGE_W-1:0] LOW4_PERMILLE = 10'd600;
  localparam logic [LWC_W-1:0]    LOW4_WINDOWS  = 8'd40;

  localparam logic [CELLS_W-1:0] CELLS_NONE  = 3'd0;
  localparam logic [CELLS_W-1:0] CELLS_TWO   = 3'd2;
  localparam logic [CELLS_W-1:0] CELLS_THREE = 3'd3;
  localparam logic [CELLS_W-1:0] CELLS_FOUR  = 3'd4;

  // One converted sample handed from front to back
  typedef struct packed {
    logic            nonzero;
    logic [MV_W-1:0] mv;
  } sample_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Pack class from the sum of the detection window (mean compared exactly)
  function automatic logic [CELLS_W-1:0] classify(input logic [SUM_W-1:0] sum);
    logic [CELLS_W-1:0] c;
    c = CELLS_TWO;
    if (sum > SUM_W'(C3_LO_MV * DETECT_N) && sum < SUM_W'(C3_HI_MV * DETECT_N)) begin
      c = CELLS_THREE;
    end else if (sum > SUM_W'(C4_LO_MV * DETECT_N) &&
                 sum < SUM_W'(C4_HI_MV * DETECT_N)) begin
      c = CELLS_FOUR;
    end
    return c;
  endfunction

  function automatic logic [MV_W-1:0] empty_mv(input logic [CELLS_W-1:0] cells);
    logic [MV_W-1:0] v;
    case (cells)
      CELLS_TWO:   v = MV_W'(CELL_EMPTY_MV * 2);
      CELLS_THREE: v = MV_W'(CELL_EMPTY_MV * 3);
      CELLS_FOUR:  v = MV_W'(CELL_EMPTY_MV * 4);
      default:     v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [DSR_W-1:0] span_mv(input logic [CELLS_W-1:0] cells);
    logic [DSR_W-1:0] v;
    case (cells)
      CELLS_TWO:   v = DSR_W'(CELL_SPAN_MV * 2);
      CELLS_THREE: v = DSR_W'(CELL_SPAN_MV * 3);
      CELLS_FOUR:  v = DSR_W'(CELL_SPAN_MV * 4);
      default:     v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/bcdm_front.sv
// Front end: accepts ADC codes, scales them to millivolts and flags skipped
// conversions, then offers the sample to the queue. Depends on bcdm_pkg.
module bcdm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bcdm_pkg::CODE_W-1:0]  code,
  input  logic [bcdm_pkg::SCALE_W-1:0] scale,
  output logic                         smp_valid,
  input  logic                         smp_ready,
  output bcdm_pkg::sample_t            smp
);
  import bcdm_pkg::*;

  logic [CODE_W+SCALE_W:0] rounded;
  logic                    stage_valid;
  sample_t                 stage;

  // Round to nearest millivolt, keep the low 16 bits
  assign rounded  = (CODE_W+SCALE_W+1)'(code) * (CODE_W+SCALE_W+1)'(scale) +
                    (CODE_W+SCALE_W+1)'(128);
  assign in_ready = !stage_valid || smp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.nonzero <= (code != '0);
      stage.mv      <= rounded[MV_W+7:8];
    end
  end

  assign smp_valid = stage_valid;
  assign smp       = stage;

endmodule

// File: src/bcdm_queue.sv
// Short sample queue between the front end and the back end, so each side
// stalls on its own. Depends on bcdm_pkg for the entry type.
module bcdm_queue #(
  parameter int DEPTH = bcdm_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  bcdm_pkg::sample_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output bcdm_pkg::sample_t rd_data
);
  import bcdm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  sample_t           slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;

  assign wr_ready = (fill != FILL_W'(DEPTH));
  assign rd_valid = (fill != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: src/bcdm_div.sv
// Shared restoring divider, one quotient bit per cycle, used for window
// averages and charge. Depends on bcdm_pkg for request/response types.
module bcdm_div (
  input  logic               clk,
  input  logic               rst,
  input  bcdm_pkg::div_req_t req,
  output bcdm_pkg::div_rsp_t rsp
);
  import bcdm_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  quo;
  logic [DSR_W-1:0]  rem;
  logic [DSR_W-1:0]  dsr;
  logic [DSR_W:0]    rem_sh;
  logic              ge;
  logic [DSR_W:0]    rem_sub;

  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, dsr});
  assign rem_sub = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= req.dividend;
      rem  <= '0;
      dsr  <= req.divisor;
      step <= STEP_W'(DIV_W - 1);
    end else if (busy) begin
      rem  <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      quo  <= {quo[DIV_W-2:0], ge};
      step <= step - 1'b1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: src/bcdm_back.sv
// Back end: accumulates samples, closes detection and monitor windows,
// computes average, charge and the low battery alarm, and holds the result.
// Depends on bcdm_pkg and the shared divider bcdm_div.
module bcdm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bcdm_pkg::THR_W-1:0]    window_threshold,
  input  logic                          smp_valid,
  output logic                          smp_ready,
  input  bcdm_pkg::sample_t             smp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bcdm_pkg::OUT_TDATA_W-1:0] out_data
);
  import bcdm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_CHG   = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_ALARM = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam int PROD_W = MV_W + CHARGE_W;

  logic [2:0]          state;
  logic                monitor_phase;
  logic [SUM_W-1:0]    sample_sum;
  logic [CNT_W-1:0]    sample_count;
  logic [CELLS_W-1:0]  cells;
  logic [MV_W-1:0]     latest_mv;
  logic [MV_W-1:0]     window_average;
  logic [CHARGE_W-1:0] charge_level;
  logic                low_flag;
  logic [LWC_W-1:0]    low_window_count;
  logic                win_done;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [MV_W-1:0]     empty;
  logic [MV_W-1:0]     excess;
  logic [PROD_W-1:0]   scaled;
  logic [LWC_W-1:0]    low_window_count_next;
  logic                out_free;

  bcdm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign smp_ready = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign empty     = empty_mv(cells);
  assign excess    = window_average - empty;
  assign scaled    = PROD_W'(excess * PROD_W'(PERMILLE));

  always_comb begin
    if (charge_level < LOW4_PERMILLE) begin
      low_window_count_next = (low_window_count == '1) ? low_window_count
                                                        : low_window_count + 1'b1;
    end else begin
      low_window_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      monitor_phase    <= 1'b0;
      sample_sum       <= '0;
      sample_count     <= '0;
      cells            <= CELLS_NONE;
      latest_mv        <= '0;
      window_average   <= '0;
      charge_level     <= '0;
      low_flag         <= 1'b0;
      low_window_count <= '0;
      win_done         <= 1'b0;
      div_req.start    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (smp_valid) begin
            if (smp.nonzero) begin
              sample_sum <= sample_sum + SUM_W'(smp.mv);
              if (sample_count != '1) begin
                sample_count <= sample_count + 1'b1;
              end
              if (monitor_phase) begin
                latest_mv <= smp.mv;
              end
            end
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          win_done <= 1'b0;
          state    <= S_EMIT;
          if (!monitor_phase) begin
            if (sample_count > CNT_W'(DETECT_SAMPLES)) begin
              cells         <= classify(sample_sum);
              monitor_phase <= 1'b1;
              sample_sum    <= '0;
              sample_count  <= '0;
              win_done      <= 1'b1;
            end
          end else if (sample_count > window_threshold && sample_count != '0) begin
            // Divider latches operands on the start beat; clear the window now
            div_req.start    <= 1'b1;
            div_req.dividend <= sample_sum;
            div_req.divisor  <= sample_count;
            sample_sum       <= '0;
            sample_count     <= '0;
            state            <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            window_average <= div_rsp.quotient[MV_W-1:0];
            state          <= S_CHG;
          end
        end
        S_CHG: begin
          if (window_average <= empty) begin
            charge_level <= '0;
            state        <= S_ALARM;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= DIV_W'(scaled);
            div_req.divisor  <= span_mv(cells);
            state            <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            charge_level <= (div_rsp.quotient > DIV_W'(CHARGE_CAP)) ? CHARGE_CAP
                                                                : div_rsp.quotient[CHARGE_W-1:0];
            state        <= S_ALARM;
          end
        end
        S_ALARM: begin
          if (cells == CELLS_THREE) begin
            low_flag <= (charge_level < LOW3_PERMILLE);
          end else if (cells == CELLS_FOUR) begin
            low_window_count <= low_window_count_next;
            low_flag         <= (low_window_count_next > LOW4_WINDOWS);
          end
          win_done <= 1'b1;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          // Hold here until the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_data <= {1'b0, win_done, low_flag, charge_level, window_average,
                   latest_mv, cells};
    end
  end

endmodule

// File: src/battery_cell_detect_and_monitor_unit.sv
// Battery cell detect and monitor unit: top level with configuration
// registers, front end, sample queue and back end.
// Depends on bcdm_pkg, bcdm_front, bcdm_queue and bcdm_back.
//
// s_axis carries one 12-bit ADC code per beat (zero = skipped conversion);
// m_axis returns exactly one result beat per input beat, in order. The
// configuration port writes the scale (index 0) and the monitor window
// threshold (index 1); write only while no beat is in flight.
// Flow: the front end scales a code into a registered stage and pushes
// it into a short queue. An item that closes no monitor window passes the
// back end states idle, evaluate and emit. An item that closes a monitor
// window runs the shared one-bit-per-cycle divider twice (average, then
// charge); the charge divide is skipped when the average is at or below
// the empty level. The back end takes no new sample until it has emitted
// the result of the last one.
// Reset: rst clears the valid flags, queue pointers and back-end state and
// loads scale 2240 and window 40. While m_axis is stalled the result is
// held and the back end, the queue and the front stage absorb up to
// QueueDepth + 2 further beats before s_axis_tready drops.
module battery_cell_detect_and_monitor_unit #(
  parameter int QueueDepth = bcdm_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_axis_tdata: [11:0] adc_code, [15:12] zero
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bcdm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // m_axis_tdata: [2:0] cell_count, [18:3] last_voltage_mv, [34:19] average_mv,
  //   [44:35] charge_permille, [45] low_battery, [46] window_done, [47] zero
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bcdm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [bcdm_pkg::CFG_W-1:0]        cfg_data
);
  import bcdm_pkg::*;

  logic [SCALE_W-1:0] mv_per_code_q8;
  logic [THR_W-1:0]   window_threshold;
  logic               fq_valid;
  logic               fq_ready;
  sample_t            fq_data;
  logic               qb_valid;
  logic               qb_ready;
  sample_t            qb_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv_per_code_q8   <= SCALE_RESET;
      window_threshold <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:  mv_per_code_q8   <= cfg_data[SCALE_W-1:0];
        REG_WINDOW: window_threshold <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bcdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .code      (s_axis_tdata[CODE_W-1:0]),
    .scale     (mv_per_code_q8),
    .smp_valid (fq_valid),
    .smp_ready (fq_ready),
    .smp       (fq_data)
  );

  bcdm_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  bcdm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .window_threshold (window_threshold),
    .smp_valid        (qb_valid),
    .smp_ready        (qb_ready),
    .smp              (qb_data),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_data         (m_axis_tdata)
  );

endmodule

// File: src/bcdm_checker.sv
// Port-level checks for the battery cell detect and monitor unit, bound to
// the top level. Depends on bcdm_pkg for port widths.
module bcdm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bcdm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import bcdm_pkg::*;

  logic [CELLS_W-1:0]  cc;
  logic [CHARGE_W-1:0] chg;
  logic                low;

  assign cc  = m_axis_tdata[2:0];
  assign chg = m_axis_tdata[44:35];
  assign low = m_axis_tdata[45];

  // No result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_cells_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (cc == CELLS_NONE || cc == CELLS_TWO ||
                       cc == CELLS_THREE || cc == CELLS_FOUR))
    else $error("illegal cell count");

  a_charge_capped: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> chg <= CHARGE_CAP)
    else $error("charge above cap");

  // Alarm is only ever raised for a 3- or 4-cell pack
  a_low_needs_pack: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && low |-> (cc == CELLS_THREE || cc == CELLS_FOUR))
    else $error("low battery flagged without 3 or 4 cells");

endmodule

bind battery_cell_detect_and_monitor_unit bcdm_checker u_bcdm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/testbench.sv
// Testbench for the battery cell detect and monitor unit: drives ADC code beats,
// predicts every result beat and checks it field by field, with a stall watchdog.
// Depends on bcdm_pkg and battery_cell_detect_and_monitor_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DETECT_COUNT   = 21;
  localparam int unsigned EMPTY_MV       = 3120;
  localparam int unsigned FULL_MV        = 4250;
  localparam int unsigned MAX_PERMILLE   = 990;
  localparam int unsigned ALARM3         = 30;
  localparam int unsigned ALARM4         = 600;
  localparam int unsigned ALARM4_WINDOWS = 40;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;

  typedef enum int {SLOW_SINK, SLOW_SOURCE, FULL_RATE} pacing_t;

  // Result beat, lowest field last
  typedef struct packed {
    logic        spare;
    logic        window_done;
    logic        low_battery;
    logic [9:0]  charge_permille;
    logic [15:0] average_mv;
    logic [15:0] last_voltage_mv;
    logic [2:0]  cell_count;
  } report_t;

  class charge_scoreboard;
    logic [11:0] scale;
    logic [15:0] window;
    bit          monitoring;
    logic [31:0] sum;
    logic [15:0] count;
    logic [2:0]  cells;
    logic [15:0] latest_mv;
    logic [15:0] average;
    logic [9:0]  charge;
    logic        low;
    logic [7:0]  low_windows;
    report_t     expected_reports[$];
    int          errors;

    function new();
      scale = 12'd2240;
      window = 16'd40;
      monitoring = 1'b0;
      sum = '0;
      count = '0;
      cells = '0;
      latest_mv = '0;
      average = '0;
      charge = '0;
      low = 1'b0;
      low_windows = '0;
      errors = 0;
    endfunction

    function void add_sample(logic [15:0] mv);
      sum += 32'(mv);
      if (count != 16'hFFFF) count++;
    endfunction

    // Advance the pack state by one accepted code and queue the result it yields
    function void note_code(logic [11:0] code);
      logic [15:0] mv;
      logic        closed;
      longint unsigned n;
      int unsigned empty, span, q;
      report_t r;
      mv = 16'((32'(code) * 32'(scale) + 32'd128) >> 8);
      closed = 1'b0;
      if (!monitoring) begin
        if (code != 0) add_sample(mv);
        if (count > DETECT_COUNT - 1) begin
          n = count;
          if (64'(sum) > 64'(10100) * n && 64'(sum) < 64'(13600) * n)
            cells = bcdm_pkg::CELLS_THREE;
          else if (64'(sum) > 64'(13800) * n && 64'(sum) < 64'(17400) * n)
            cells = bcdm_pkg::CELLS_FOUR;
          else
            cells = bcdm_pkg::CELLS_TWO;
          monitoring = 1'b1;
          sum = '0;
          count = '0;
          closed = 1'b1;
        end
      end else begin
        if (code != 0) begin
          latest_mv = mv;
          add_sample(mv);
        end
        if (count > window && count != 0) begin
          average = 16'(sum / 32'(count));
          sum = '0;
          count = '0;
          empty = EMPTY_MV * cells;
          span = (FULL_MV - EMPTY_MV) * cells;
          if (span == 0 || average <= empty) begin
            charge = '0;
          end else begin
            q = ((average - empty) * 1000) / span;
            charge = (q > MAX_PERMILLE) ? 10'(MAX_PERMILLE) : 10'(q);
          end
          if (cells == bcdm_pkg::CELLS_THREE) begin
            low = (charge < ALARM3);
          end else if (cells == bcdm_pkg::CELLS_FOUR) begin
            if (charge < ALARM4) begin
              if (low_windows != 8'hFF) low_windows++;
            end else begin
              low_windows = '0;
            end
            low = (low_windows > ALARM4_WINDOWS);
          end
          closed = 1'b1;
        end
      end
      r = '0;
      r.cell_count = cells;
      r.last_voltage_mv = latest_mv;
      r.average_mv = average;
      r.charge_permille = charge;
      r.low_battery = low;
      r.window_done = closed;
      expected_reports.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic [bcdm_pkg::OUT_TDATA_W-1:0] data);
      report_t got, want;
      got = report_t'(data);
      if (expected_reports.size() == 0) begin
        $error("result beat with no prediction pending: %h", data);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare("cell_count", 32'(want.cell_count), 32'(got.cell_count));
      compare("last_voltage_mv", 32'(want.last_voltage_mv), 32'(got.last_voltage_mv));
      compare("average_mv", 32'(want.average_mv), 32'(got.average_mv));
      compare("charge_permille", 32'(want.charge_permille), 32'(got.charge_permille));
      compare("low_battery", 32'(want.low_battery), 32'(got.low_battery));
      compare("window_done", 32'(want.window_done), 32'(got.window_done));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [bcdm_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;   // [11:0] adc_code, [15:12] zero
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [2:0] cell_count, [18:3] last_voltage_mv, [34:19] average_mv,
  // [44:35] charge_permille, [45] low_battery, [46] window_done, [47] zero
  logic [bcdm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = bcdm_pkg::REG_SCALE;
  logic [bcdm_pkg::CFG_W-1:0] cfg_data = '0;

  charge_scoreboard sb;
  int send_idle = 34;
  int recv_idle = 86;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int quiet = 0;

  battery_cell_detect_and_monitor_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side: check each accepted beat, then pick the next ready
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_code(logic [11:0] code);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= bcdm_pkg::IN_TDATA_W'(code);
    do @(posedge clk); while (!s_axis_tready);
    sb.note_code(code);
  endtask

  // Drop valid and hold until every predicted beat has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [11:0] scale, logic [15:0] window);
    cfg_we <= 1'b1;
    cfg_index <= bcdm_pkg::REG_SCALE;
    cfg_data <= bcdm_pkg::CFG_W'(scale);
    @(posedge clk);
    cfg_index <= bcdm_pkg::REG_WINDOW;
    cfg_data <= window;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.scale = scale;
    sb.window = window;
  endtask

  function automatic logic [11:0] code_for_mv(int mv);
    int c;
    if (sb.scale == 0) return 12'($urandom_range(4095, 1));
    if (mv < 0) mv = 0;
    c = (mv * 256 + int'(sb.scale) / 2) / int'(sb.scale);
    if (c < 1) c = 1;
    if (c > 4095) c = 4095;
    return 12'(c);
  endfunction

  // A run of samples around one per-cell voltage; noisy runs mix in skips and raw codes
  task automatic send_run(int per_cell_mv, int len, bit clean);
    int mv, jitter, roll;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(99);
      mv = per_cell_mv * int'(sb.cells);
      jitter = mv / 100 + 1;
      mv = mv + int'($urandom_range(2 * jitter)) - jitter;
      if (!clean && roll < 8) send_code('0);
      else if (!clean && roll < 14) send_code(12'($urandom()));
      else send_code(code_for_mv(mv));
    end
  endtask

  task automatic run_phase(logic [11:0] scale, logic [15:0] window, int items, pacing_t pace);
    int sent, len, level;
    bit long_low;
    set_config(scale, window);
    case (pace)
      SLOW_SINK: begin
        send_idle = 34;
        recv_idle = 86;
      end
      SLOW_SOURCE: begin
        send_idle = 86;
        recv_idle = 34;
      end
      default: begin
        send_idle = 0;
        recv_idle = 0;
        hold_req = 1'b1;
      end
    endcase
    sent = 0;
    while (sent < items) begin
      long_low = ($urandom_range(5) == 0);
      len = long_low ? int'($urandom_range(250, 100)) : int'($urandom_range(60, 5));
      if (len > items - sent) len = items - sent;
      case (long_low ? 2 : $urandom_range(5))
        0: level = $urandom_range(3119, 2500);
        1: level = $urandom_range(3160, 3120);
        2: level = $urandom_range(3800, 3120);
        3: level = $urandom_range(4250, 3800);
        4: level = $urandom_range(4800, 4240);
        default: level = $urandom_range(5000, 800);
      endcase
      send_run(level, len, 1'b0);
      sent += len;
    end
    drain();
  endtask

  initial begin
    int center;
    int per_cell[5];
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Detection window: skips, both code extremes, the rest near one pack class
    case ($urandom_range(2))
      0: center = 11850;
      1: center = 15600;
      default: center = $urandom_range(1) ? 7800 : 21000;
    endcase
    send_code('0);
    send_code(12'd4095);
    send_code(12'd1);
    for (int i = 0; i < 19; i++) begin
      if (i == 9) send_code('0);
      send_code(12'(int'(code_for_mv(center)) + int'($urandom_range(40)) - 20));
    end
    drain();

    // Window of one: charge at empty, alarm edges, full and over full
    set_config(12'd2240, 16'd0);
    per_cell = '{3100, 3153, 3798, 4250, 4400};
    foreach (per_cell[i]) send_code(code_for_mv(per_cell[i] * int'(sb.cells)));
    send_code('0);
    send_code(12'd4095);
    send_code(12'd1);
    // Long clean low stretch: for a four-cell pack, drives the low window count into saturation
    send_run(3400, 270, 1'b1);
    drain();

    run_phase(12'd2240, 16'd0, 200, SLOW_SINK);
    run_phase(12'd0, 16'd2, 60, SLOW_SINK);
    run_phase(12'd4095, 16'd1, 250, SLOW_SINK);
    run_phase(12'd1, 16'd3, 150, SLOW_SOURCE);
    run_phase(12'($urandom_range(3000, 1500)), 16'd40, 300, SLOW_SOURCE);
    run_phase(12'd4095, 16'd65535, 60, SLOW_SOURCE);
    run_phase(12'd2240, 16'd5, 400, FULL_RATE);
    run_phase(12'd2240, 16'd0, 300, FULL_RATE);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
